// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property, sampled on each clock edge
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sed_pkg.sv -----
package sed_pkg;

    localparam int CAPACITY      = 32;
    localparam int HOUR_W        = 5;
    localparam int MIN_W         = 6;
    localparam int KEY_W         = 11;
    localparam int DESC_WORD_W   = 64;
    localparam int DESC_WORDS    = 5;
    localparam int DESC_W        = DESC_WORD_W * DESC_WORDS;
    localparam int STATUS_W      = 3;
    localparam int FIELDS_W      = HOUR_W + MIN_W + DESC_W;
    localparam int TDATA_W       = ((FIELDS_W + 7) / 8) * 8;
    localparam logic [KEY_W-1:0] MIN_PER_HOUR = KEY_W'(60);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DRAIN  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    // desc holds word 0 in the top bits so a plain unsigned compare orders it
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [DESC_W-1:0] desc;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   gt;
        t_entry entry;
    } t_link;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] f_key(input logic [HOUR_W-1:0] hour,
                                               input logic [MIN_W-1:0]  minute);
        f_key = KEY_W'(hour) * MIN_PER_HOUR + KEY_W'(minute);
    endfunction

endpackage

// ----- hw/rtl/sorted_event_insert_table.sv -----
// Sorted event table: up to CAPACITY events kept in order of hour*60+minute, ties by
// description, in a chain of cells. An insert word gives one result
// word (inserted, duplicate dropped or full dropped). A drain word shifts the chain one
// entry toward its head per cycle while the output register is free, and the head cell
// feeds the output register, with tlast on the final entry; an empty table answers one
// word with the empty status. No input is taken while a drain is running.
`include "assert_macros.svh"

module sorted_event_insert_table import sed_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // hour, minute, desc_word_0 .. desc_word_4, zero fill
    input  logic [TDATA_W-1:0]  i_s_tdata,
    // command
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // out_hour, out_minute, out_desc_0 .. out_desc_4, zero fill
    output logic [TDATA_W-1:0]  o_m_tdata,
    // status
    output logic [STATUS_W-1:0] o_m_tuser,
    output logic                o_m_tlast
);

    localparam int WW = DESC_WORD_W;
    localparam int D0 = HOUR_W + MIN_W;

    t_state           r_state, n_state;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic             r_out_last, n_out_last;
    t_entry           r_out_entry, n_out_entry;

    t_entry           w_new;
    logic [KEY_W-1:0] w_new_key;
    t_cmd             w_cmd;
    t_cell_ctl        w_ctl;
    t_link            w_link [CAPACITY];
    t_link            w_prev [CAPACITY];
    t_link            w_next [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_valid;
    logic             w_dup, w_full, w_empty;
    logic             w_s_acc, w_out_free, w_ins_go, w_drain_step;

    always_comb begin
        w_new.hour   = i_s_tdata[HOUR_W-1:0];
        w_new.minute = i_s_tdata[D0-1:HOUR_W];
        w_new.desc   = {i_s_tdata[D0+WW-1:D0],
                        i_s_tdata[D0+2*WW-1:D0+WW],
                        i_s_tdata[D0+3*WW-1:D0+2*WW],
                        i_s_tdata[D0+4*WW-1:D0+3*WW],
                        i_s_tdata[D0+5*WW-1:D0+4*WW]};
        w_new_key    = f_key(w_new.hour, w_new.minute);
        w_cmd        = t_cmd'(i_s_tuser);
    end

    assign w_dup   = |w_eq;
    assign w_full  = w_link[CAPACITY-1].valid;
    assign w_empty = !w_link[0].valid;

    assign w_out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready   = (r_state == S_IDLE) && w_out_free;
    assign w_s_acc      = i_s_tvalid && o_s_tready;
    assign w_ins_go     = w_s_acc && (w_cmd == CMD_INSERT) && !w_dup && !w_full;
    assign w_drain_step = (r_state == S_DRAIN) && w_out_free;
    assign w_ctl.insert = w_ins_go;
    assign w_ctl.shift  = w_drain_step;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_prev[gi] = '{valid: 1'b1, gt: 1'b0, entry: '0};
            end else begin : g_body
                assign w_prev[gi] = w_link[gi-1];
            end
            if (gi == CAPACITY-1) begin : g_tail
                assign w_next[gi] = '0;
            end else begin : g_inner
                assign w_next[gi] = w_link[gi+1];
            end
            assign w_valid[gi] = w_link[gi].valid;

            sed_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_new     (w_new),
                .i_new_key (w_new_key),
                .i_prev    (w_prev[gi]),
                .i_next    (w_next[gi]),
                .o_link    (w_link[gi]),
                .o_eq      (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_entry  = r_out_entry;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_s_acc) begin
            case (w_cmd)
                CMD_INSERT: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_entry = '0;
                    if (w_dup) begin
                        n_out_status = ST_DUP;
                    end else if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_out_status = ST_INSERTED;
                    end
                end
                CMD_DRAIN: begin
                    if (w_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_last   = 1'b1;
                        n_out_entry  = '0;
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
        if (w_drain_step) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_ENTRY;
            n_out_entry  = w_link[0].entry;
            n_out_last   = !w_link[1].valid;
            if (!w_link[1].valid) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_entry  <= n_out_entry;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {(TDATA_W-FIELDS_W)'(0),
                         r_out_entry.desc[WW-1:0],
                         r_out_entry.desc[2*WW-1:WW],
                         r_out_entry.desc[3*WW-1:2*WW],
                         r_out_entry.desc[4*WW-1:3*WW],
                         r_out_entry.desc[5*WW-1:4*WW],
                         r_out_entry.minute,
                         r_out_entry.hour};

    `ASSERT_CHK(a_drain_nonempty, i_clk, i_rst_n, (r_state != S_DRAIN) || w_link[0].valid, "drain running on empty chain")
    `ASSERT_CHK(a_valid_packed, i_clk, i_rst_n, ((w_valid >> 1) & ~w_valid) == '0, "hole in cell chain")
    `ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ins_go, $countones(w_valid) == $countones($past(w_valid)) + 1, "insert did not add one entry")

endmodule

// ----- hw/rtl/sed_cell.sv -----
module sed_cell import sed_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_new,
    input  logic [KEY_W-1:0] i_new_key,
    input  t_link            i_prev,
    input  t_link            i_next,
    output t_link            o_link,
    output logic             o_eq
);

    logic             r_valid;
    logic             n_valid;
    t_entry           r_entry;
    t_entry           n_entry;
    logic [KEY_W-1:0] w_key;
    logic             w_gt;

    always_comb begin
        w_key = f_key(r_entry.hour, r_entry.minute);
        w_gt  = r_valid && ((w_key > i_new_key) ||
                            ((w_key == i_new_key) && (r_entry.desc > i_new.desc)));
        o_eq  = r_valid && (w_key == i_new_key) && (r_entry.desc == i_new.desc);
        o_link.valid = r_valid;
        o_link.gt    = w_gt;
        o_link.entry = r_entry;
    end

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_valid = i_next.valid;
            n_entry = i_next.entry;
        end else if (i_ctl.insert && (!r_valid || w_gt)) begin
            if (i_prev.gt) begin
                n_valid = 1'b1;
                n_entry = i_prev.entry;
            end else if (i_prev.valid) begin
                n_valid = 1'b1;
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
